>>> hdl/tsf_pkg.sv
package tsf_pkg;

    localparam int COUNT_BITS = 32;
    localparam int EXP_W      = $clog2(COUNT_BITS + 1);
    localparam int N_COORDS   = 9;
    localparam int J_W        = $clog2(N_COORDS + 1);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [63:0] K_GOLD  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] K_MIX1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] K_MIX2  = 64'h94D049BB133111EB;
    localparam logic [63:0] K_TRISD = 64'hCBF29CE484222325;
    localparam logic [63:0] K_CNTSD = 64'h243F6A8885A308D3;
    localparam int          PRIME_SH  = 40;
    localparam logic [63:0] PRIME_LOW = 64'h1B3;

    // index of the count mix, after the nine coordinate mixes
    localparam logic [J_W-1:0] CNT_IDX = J_W'(N_COORDS);

    typedef logic [2:0][63:0] t_corner;

    // coordinates packed corner by corner, x y z within each corner
    typedef struct packed {
        logic [N_COORDS-1:0][63:0] coord;
        logic                      last;
    } t_item;

endpackage

>>> hdl/tsf_front.sv
module tsf_front
    import tsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_full,
    input  t_corner i_a,
    input  t_corner i_b,
    input  t_corner i_c,
    input  logic    i_last,
    input  logic    i_q_full,
    output logic    o_q_push,
    output t_item   o_q_item
);

    logic    r_vld, n_vld;
    t_corner r_a, r_b, r_c;
    logic    r_last;
    logic    lt_ba, lt_ca, lt_cb;
    logic    sel_b, sel_c;

    function automatic logic is_nan(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] v);
        return v[62:0] == 63'd0;
    endfunction

    function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if (is_zero(a) && is_zero(b)) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

    function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if (is_zero(a) && is_zero(b)) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = a[63];
        end else if (!a[63]) begin
            res = (a < b);
        end else begin
            res = (a > b);
        end
        return res;
    endfunction

    function automatic logic corner_less(input t_corner l, input t_corner r);
        logic res;
        if (!f_eq(l[0], r[0])) begin
            res = f_lt(l[0], r[0]);
        end else if (!f_eq(l[1], r[1])) begin
            res = f_lt(l[1], r[1]);
        end else begin
            res = f_lt(l[2], r[2]);
        end
        return res;
    endfunction

    assign o_full   = r_vld && i_q_full;
    assign o_q_push = r_vld && !i_q_full;

    assign lt_ba = corner_less(r_b, r_a);
    assign lt_ca = corner_less(r_c, r_a);
    assign lt_cb = corner_less(r_c, r_b);

    // C takes the lead only if strictly less than whichever of A and B leads
    assign sel_c = lt_ba ? lt_cb : lt_ca;
    assign sel_b = lt_ba && !sel_c;

    always_comb begin
        if (sel_c) begin
            o_q_item.coord = {r_b, r_a, r_c};
        end else if (sel_b) begin
            o_q_item.coord = {r_a, r_c, r_b};
        end else begin
            o_q_item.coord = {r_c, r_b, r_a};
        end
        o_q_item.last = r_last;
    end

    always_comb begin
        n_vld = r_vld;
        if (i_push && !o_full) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_c    <= i_c;
            r_last <= i_last;
        end
    end

endmodule

>>> hdl/tsf_fifo.sv
module tsf_fifo
    import tsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_head
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_PW-1:0]  r_wp, n_wp;
    logic [Q_PW-1:0]  r_rp, n_rp;
    logic [Q_CW-1:0]  r_cnt, n_cnt;

    function automatic logic [Q_PW-1:0] ptr_inc(input logic [Q_PW-1:0] p);
        logic [Q_PW-1:0] res;
        if (p == Q_PW'(Q_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + Q_PW'(1);
        end
        return res;
    endfunction

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ptr_inc(r_wp);
        end
        if (i_pop) begin
            n_rp = ptr_inc(r_rp);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

>>> hdl/tsf_back.sv
module tsf_back
    import tsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_head,
    output logic        o_q_pop,
    output logic [63:0] o_fingerprint,
    output logic [31:0] o_triangles_seen,
    output logic        o_set_closed,
    output logic        o_empty,
    input  logic        i_pop
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_GOLD  = 7'b000_0010,
        S_MIX1  = 7'b000_0100,
        S_MIX2  = 7'b000_1000,
        S_CHAIN = 7'b001_0000,
        S_ACC   = 7'b010_0000,
        S_OUT   = 7'b100_0000
    } t_state;

    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_X1  = 2'd1;
    localparam logic [1:0] PH_X2  = 2'd2;
    localparam int         CNT64_PAD = 64 - COUNT_BITS;

    t_state                r_state, n_state;
    logic [1:0]            r_ph, n_ph;
    logic [J_W-1:0]        r_j, n_j;
    logic [1:0]            r_axis, n_axis;
    logic [63:0]           r_h, n_h;
    logic [63:0]           r_x, n_x;
    logic [63:0]           r_p, n_p;
    logic [63:0]           r_sum, n_sum;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [EXP_W-1:0]      r_e, n_e;
    logic [COUNT_BITS:0]   r_npow, n_npow;
    logic [63:0]           r_dbl, n_dbl;
    logic                  r_last, n_last;
    logic                  r_ovld, n_ovld;
    logic [63:0]           r_fp, n_fp;
    logic [31:0]           r_seen, n_seen;
    logic                  r_closed, n_closed;

    logic [63:0]           mul_a, mul_b;
    logic [31:0]           ml, mr;
    logic [63:0]           mprod, full;
    logic [63:0]           bits_raw, bits_f, m0, s_mix;
    logic [63:0]           cnt64, dbl_val, mant_sh;
    logic [5:0]            dbl_sh;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  mul_done;

    assign o_fingerprint    = r_fp;
    assign o_triangles_seen = r_seen;
    assign o_set_closed     = r_closed;
    assign o_empty          = !r_ovld;
    assign o_q_pop          = (r_state == S_ACC);

    // one 32x32 partial product per cycle, low 64 bits of the full product
    always_comb begin
        mul_a = (r_state == S_GOLD) ? r_h : r_x;
        case (r_state)
            S_GOLD:  mul_b = K_GOLD;
            S_MIX1:  mul_b = K_MIX1;
            default: mul_b = K_MIX2;
        endcase
        case (r_ph)
            PH_LO: begin
                ml = mul_a[31:0];
                mr = mul_b[31:0];
            end
            PH_X1: begin
                ml = mul_a[31:0];
                mr = mul_b[63:32];
            end
            default: begin
                ml = mul_a[63:32];
                mr = mul_b[31:0];
            end
        endcase
    end

    assign mprod    = {32'd0, ml} * {32'd0, mr};
    assign full     = {r_p[63:32] + mprod[31:0], r_p[31:0]};
    assign mul_done = (r_ph == PH_X2);

    always_comb begin
        bits_raw = r_dbl;
        for (int i = 0; i < N_COORDS; i++) begin
            if (r_j == J_W'(i)) begin
                bits_raw = i_q_head.coord[i];
            end
        end
    end

    // fold -0 onto +0
    assign bits_f = (bits_raw[62:0] == 63'd0) ? 64'd0 : bits_raw;
    assign m0     = bits_f ^ full;
    assign s_mix  = full ^ (full >> 31);

    // count as a double: exponent tracked in r_e as floor(log2) + 1
    assign cnt64   = {{CNT64_PAD{1'b0}}, r_cnt};
    assign dbl_sh  = 6'd53 - 6'(r_e);
    assign mant_sh = cnt64 << dbl_sh;
    assign dbl_val = (r_e == '0) ? 64'd0
                   : {1'b0, 11'd1022 + 11'(r_e), mant_sh[51:0]};
    assign cnt_inc = r_cnt + COUNT_BITS'(1);

    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_j      = r_j;
        n_axis   = r_axis;
        n_h      = r_h;
        n_x      = r_x;
        n_p      = r_p;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_e      = r_e;
        n_npow   = r_npow;
        n_dbl    = r_dbl;
        n_last   = r_last;
        n_ovld   = r_ovld && !i_pop;
        n_fp     = r_fp;
        n_seen   = r_seen;
        n_closed = r_closed;

        if (r_state == S_GOLD || r_state == S_MIX1 || r_state == S_MIX2) begin
            if (r_ph == PH_LO) begin
                n_p = mprod;
            end else begin
                n_p = full;
            end
            n_ph = mul_done ? PH_LO : r_ph + 2'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_h     = K_TRISD;
                    n_j     = '0;
                    n_axis  = '0;
                    n_ph    = PH_LO;
                    n_state = S_GOLD;
                end
            end
            S_GOLD: begin
                if (mul_done) begin
                    n_x     = m0 ^ (m0 >> 30);
                    n_state = S_MIX1;
                end
            end
            S_MIX1: begin
                if (mul_done) begin
                    n_x     = full ^ (full >> 27);
                    n_state = S_MIX2;
                end
            end
            S_MIX2: begin
                if (mul_done) begin
                    n_x     = s_mix;
                    n_state = (r_j == CNT_IDX) ? S_OUT : S_CHAIN;
                end
            end
            S_CHAIN: begin
                n_h = (r_x << PRIME_SH) + (r_x * PRIME_LOW) + {62'd0, r_axis} + 64'd1;
                n_j = r_j + J_W'(1);
                n_axis = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                n_state = (r_j == CNT_IDX - J_W'(1)) ? S_ACC : S_GOLD;
            end
            S_ACC: begin
                // fold the triangle in, drop the queue entry, prepare the count mix
                n_sum  = r_sum + r_h;
                n_last = i_q_head.last;
                if (r_cnt != '1) begin
                    n_cnt = cnt_inc;
                    if ({1'b0, cnt_inc} == r_npow) begin
                        n_e    = r_e + EXP_W'(1);
                        n_npow = r_npow << 1;
                    end
                end
                n_h     = K_CNTSD;
                n_state = S_OUT;
                n_j     = CNT_IDX;
                n_state = S_GOLD;
                n_dbl   = r_dbl;
            end
            S_OUT: begin
                if (!r_ovld || i_pop) begin
                    n_ovld   = 1'b1;
                    n_fp     = r_x ^ r_sum;
                    n_seen   = cnt64[31:0];
                    n_closed = r_last;
                    if (r_last) begin
                        n_sum  = '0;
                        n_cnt  = '0;
                        n_e    = '0;
                        n_npow = (COUNT_BITS + 1)'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the double of the count is loaded in the first step of the count mix, the cycle after S_ACC updates the count
        if (r_state == S_GOLD && r_j == CNT_IDX && r_ph == PH_LO) begin
            n_dbl = dbl_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_LO;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_e     <= '0;
            r_npow  <= (COUNT_BITS + 1)'(1);
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_e     <= n_e;
            r_npow  <= n_npow;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_axis   <= n_axis;
        r_h      <= n_h;
        r_x      <= n_x;
        r_p      <= n_p;
        r_dbl    <= n_dbl;
        r_last   <= n_last;
        r_fp     <= n_fp;
        r_seen   <= n_seen;
        r_closed <= n_closed;
    end

endmodule

>>> hdl/triangle_set_fingerprint.sv
// Triangle set fingerprint.
// Input side is a queue: present the nine coordinate words and last_of_set,
// raise i_push; the word is taken at a clock edge where o_full is low.
// Result side is a queue too: while o_empty is low the oldest result sits on
// o_fingerprint, o_triangles_seen and o_set_closed, and i_pop takes it.
// Every triangle gives one result: the running set hash and the count, with
// o_set_closed repeating last_of_set; after such a result the set restarts.
// A front stage picks the leading corner and writes a two-entry queue; the
// back end hashes one triangle at a time in ten scalar mixes, nine chain
// steps and bookkeeping. The mixes build each 64-bit product from 32x32
// partial products on a single multiplier; the chain steps multiply by the
// prime constant apart from it.
// Synchronous reset empties both queues and clears sum and count.
// A stalled result holds in the output register; the back end waits behind
// it, the queue fills and o_full then holds off new words.
module triangle_set_fingerprint
    import tsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_a_x,
    input  logic [63:0] i_a_y,
    input  logic [63:0] i_a_z,
    input  logic [63:0] i_b_x,
    input  logic [63:0] i_b_y,
    input  logic [63:0] i_b_z,
    input  logic [63:0] i_c_x,
    input  logic [63:0] i_c_y,
    input  logic [63:0] i_c_z,
    input  logic        i_last_of_set,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_fingerprint,
    output logic [31:0] o_triangles_seen,
    output logic        o_set_closed
);

    logic  q_push, q_full, q_pop, q_empty;
    t_item q_in, q_head;

    tsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_a      ({i_a_z, i_a_y, i_a_x}),
        .i_b      ({i_b_z, i_b_y, i_b_x}),
        .i_c      ({i_c_z, i_c_y, i_c_x}),
        .i_last   (i_last_of_set),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    tsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    tsf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_head         (q_head),
        .o_q_pop          (q_pop),
        .o_fingerprint    (o_fingerprint),
        .o_triangles_seen (o_triangles_seen),
        .o_set_closed     (o_set_closed),
        .o_empty          (o_empty),
        .i_pop            (i_pop)
    );

endmodule
